// File: rtl/filename_match_scorer_core_macros.svh
// ----------------------------------------------------------------------------
// filename match scorer assertion macros
// shared property forms for the scorer modules, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FILENAME_MATCH_SCORER_CORE_MACROS_SVH
`define FILENAME_MATCH_SCORER_CORE_MACROS_SVH

// same-cycle implication
`define FMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// filename match scorer package
// sizes, register indexes, score codes, cell control and ascii folding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fms_pkg;

  localparam int QueryMax = 16;
  localparam int QIdxW    = $clog2(QueryMax);
  localparam int QLenW    = 5;
  localparam int NameMax  = 255;
  localparam int CntW     = $clog2(NameMax + 1);
  localparam int ScoreW   = 10;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgQueryLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQueryHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgQueryLen  = 2'd2;

  localparam logic [ScoreW-1:0] ScoreExact   = 10'd1000;
  localparam logic [ScoreW-1:0] ScorePrefix  = 10'd500;
  localparam logic [ScoreW-1:0] ScoreName    = 10'd100;
  localparam logic [ScoreW-1:0] ScorePath    = 10'd50;
  localparam logic [ScoreW-1:0] ScoreSubseq  = 10'd25;
  localparam logic [ScoreW-1:0] ScoreNone    = 10'd0;

  typedef struct packed {
    logic name_upd;
    logic path_upd;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/filename_match_scorer_core.sv
// ----------------------------------------------------------------------------
// filename match scorer core
// scores a candidate name and path against a configured query of up to
// sixteen bytes using a row of compare cells
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle while in_stall_o is low, and
// action_i marks it as a name or a path byte. Every query position has its
// own cell that compares the folded byte with its query byte and shifts the
// partial-hit bits to its neighbor, so a byte is fully absorbed in the cycle
// it is accepted and the next request can follow right behind it. The score
// for a candidate is registered into the output buffer when its last path
// byte is accepted. A two-deep output buffer lets input continue while a
// score waits; in_stall_o rises only when two scores are held and not yet
// taken. Query registers should be written between candidates.
`timescale 1ns / 1ps
`include "filename_match_scorer_core_macros.svh"

module filename_match_scorer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fms_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fms_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        ends_string_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fms_pkg::ScoreW-1:0]  score_o
);

  logic [fms_pkg::CfgW-1:0]  qlow_q;
  logic [fms_pkg::CfgW-1:0]  qhigh_q;
  logic [fms_pkg::QLenW-1:0] qlen_raw_q;

  logic [2*fms_pkg::CfgW-1:0]  qword;
  logic [fms_pkg::QLenW-1:0]   qlen;
  logic [fms_pkg::QLenW-1:0]   qlen_m1;
  logic [fms_pkg::QueryMax-1:0] top_mask;
  logic [7:0]                  text_fold;

  fms_pkg::cell_ctrl_t cell_ctrl;
  logic accept;

  logic [fms_pkg::QueryMax-1:0] match_vec;
  logic [fms_pkg::QueryMax-1:0] name_hit, path_hit;
  logic [fms_pkg::QueryMax-1:0] name_next, path_next;
  logic [fms_pkg::QueryMax-1:0] name_chain, path_chain;

  logic                      name_has_q, name_has_d;
  logic                      path_has_q, path_has_d;
  logic                      path_has_now;
  logic                      prefix_ok_q, prefix_ok_d;
  logic [fms_pkg::CntW-1:0]  name_cnt_q, name_cnt_d;
  logic [fms_pkg::CntW-1:0]  qlen_ext;
  logic [fms_pkg::QLenW-1:0] subseq_pos_q, subseq_pos_d;
  logic [fms_pkg::ScoreW-1:0] score;
  logic                      buf_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q     <= '0;
      qhigh_q    <= '0;
      qlen_raw_q <= fms_pkg::QLenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fms_pkg::CfgQueryLow:  qlow_q     <= cfg_data_i;
        fms_pkg::CfgQueryHigh: qhigh_q    <= cfg_data_i;
        fms_pkg::CfgQueryLen:  qlen_raw_q <= cfg_data_i[fms_pkg::QLenW-1:0];
        default: ;
      endcase
    end
  end

  assign qword = {qhigh_q, qlow_q};

  always_comb begin
    qlen = qlen_raw_q;
    if (qlen_raw_q == '0) begin
      qlen = fms_pkg::QLenW'(1);
    end else if (qlen_raw_q > fms_pkg::QLenW'(fms_pkg::QueryMax)) begin
      qlen = fms_pkg::QLenW'(fms_pkg::QueryMax);
    end
  end

  assign qlen_m1   = qlen - fms_pkg::QLenW'(1);
  assign top_mask  = fms_pkg::QueryMax'(1) << qlen_m1;
  assign qlen_ext  = fms_pkg::CntW'(qlen);
  assign text_fold = fms_pkg::fold(text_byte_i);

  assign accept             = in_valid_i && !in_stall_o;
  assign cell_ctrl.name_upd = accept && !action_i;
  assign cell_ctrl.path_upd = accept && action_i;
  assign cell_ctrl.clear    = accept && action_i && ends_string_i;

  assign name_chain = {name_hit[fms_pkg::QueryMax-2:0], 1'b1};
  assign path_chain = {path_hit[fms_pkg::QueryMax-2:0], 1'b1};

  for (genvar k = 0; k < fms_pkg::QueryMax; k++) begin : g_cell
    fms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .text_i      (text_fold),
      .query_i     (fms_pkg::fold(qword[8*k +: 8])),
      .active_i    (fms_pkg::QLenW'(k) < qlen),
      .name_prev_i (name_chain[k]),
      .path_prev_i (path_chain[k]),
      .match_o     (match_vec[k]),
      .name_hit_o  (name_hit[k]),
      .path_hit_o  (path_hit[k]),
      .name_next_o (name_next[k]),
      .path_next_o (path_next[k])
    );
  end

  assign path_has_now = path_has_q || ((path_next & top_mask) != '0);

  always_comb begin
    name_has_d   = name_has_q;
    path_has_d   = path_has_q;
    prefix_ok_d  = prefix_ok_q;
    name_cnt_d   = name_cnt_q;
    subseq_pos_d = subseq_pos_q;
    if (cell_ctrl.clear) begin
      name_has_d   = 1'b0;
      path_has_d   = 1'b0;
      prefix_ok_d  = 1'b1;
      name_cnt_d   = '0;
      subseq_pos_d = '0;
    end else if (cell_ctrl.name_upd) begin
      if ((name_next & top_mask) != '0) begin
        name_has_d = 1'b1;
      end
      if (name_cnt_q < qlen_ext && !match_vec[name_cnt_q[fms_pkg::QIdxW-1:0]]) begin
        prefix_ok_d = 1'b0;
      end
      if (name_cnt_q != fms_pkg::CntW'(fms_pkg::NameMax)) begin
        name_cnt_d = name_cnt_q + fms_pkg::CntW'(1);
      end
      if (subseq_pos_q < qlen && match_vec[subseq_pos_q[fms_pkg::QIdxW-1:0]]) begin
        subseq_pos_d = subseq_pos_q + fms_pkg::QLenW'(1);
      end
    end else if (cell_ctrl.path_upd) begin
      path_has_d = path_has_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_has_q   <= 1'b0;
      path_has_q   <= 1'b0;
      prefix_ok_q  <= 1'b1;
      name_cnt_q   <= '0;
      subseq_pos_q <= '0;
    end else begin
      name_has_q   <= name_has_d;
      path_has_q   <= path_has_d;
      prefix_ok_q  <= prefix_ok_d;
      name_cnt_q   <= name_cnt_d;
      subseq_pos_q <= subseq_pos_d;
    end
  end

  always_comb begin
    if (prefix_ok_q && name_cnt_q == qlen_ext) begin
      score = fms_pkg::ScoreExact;
    end else if (prefix_ok_q && name_cnt_q > qlen_ext) begin
      score = fms_pkg::ScorePrefix;
    end else if (name_has_q) begin
      score = fms_pkg::ScoreName;
    end else if (path_has_now) begin
      score = fms_pkg::ScorePath;
    end else if (subseq_pos_q >= qlen) begin
      score = fms_pkg::ScoreSubseq;
    end else begin
      score = fms_pkg::ScoreNone;
    end
  end

  fms_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cell_ctrl.clear),
    .score_i     (score),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .score_o     (score_o)
  );

  assign in_stall_o = buf_full;

  `FMS_ASSERT_IMPL(a_pos_bound, subseq_pos_q != '0, subseq_pos_q <= fms_pkg::QLenW'(fms_pkg::QueryMax), "subsequence position past query")
  `FMS_ASSERT_NEXT(a_clear_on_end, cell_ctrl.clear, name_cnt_q == '0 && prefix_ok_q && !name_has_q && !path_has_q && subseq_pos_q == '0, "state not cleared after last path byte")
  `FMS_ASSERT_NEXT(a_result_on_end, cell_ctrl.clear, out_valid_o, "no score after last path byte")

endmodule

// File: rtl/fms_cell.sv
// ----------------------------------------------------------------------------
// filename match scorer cell
// one query position: compares the text byte with its query byte and holds
// the name and path partial-hit bits handed on to the next cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fms_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]         text_i,
  input  logic [7:0]         query_i,
  input  logic               active_i,
  input  logic               name_prev_i,
  input  logic               path_prev_i,
  output logic               match_o,
  output logic               name_hit_o,
  output logic               path_hit_o,
  output logic               name_next_o,
  output logic               path_next_o
);

  logic name_hit_q, name_hit_d;
  logic path_hit_q, path_hit_d;

  assign match_o     = active_i && (text_i == query_i);
  assign name_next_o = name_prev_i & match_o;
  assign path_next_o = path_prev_i & match_o;

  always_comb begin
    name_hit_d = name_hit_q;
    path_hit_d = path_hit_q;
    if (ctrl_i.clear) begin
      name_hit_d = 1'b0;
      path_hit_d = 1'b0;
    end else begin
      if (ctrl_i.name_upd) begin
        name_hit_d = name_next_o;
      end
      if (ctrl_i.path_upd) begin
        path_hit_d = path_next_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_hit_q <= 1'b0;
      path_hit_q <= 1'b0;
    end else begin
      name_hit_q <= name_hit_d;
      path_hit_q <= path_hit_d;
    end
  end

  assign name_hit_o = name_hit_q;
  assign path_hit_o = path_hit_q;

endmodule

// File: rtl/fms_out_buf.sv
// ----------------------------------------------------------------------------
// filename match scorer output buffer
// output register plus one skid slot so requests keep flowing while a
// score waits downstream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "filename_match_scorer_core_macros.svh"

module fms_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [fms_pkg::ScoreW-1:0] score_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fms_pkg::ScoreW-1:0] score_o
);

  logic                       out_valid_q, out_valid_d;
  logic [fms_pkg::ScoreW-1:0] out_score_q, out_score_d;
  logic                       skid_valid_q, skid_valid_d;
  logic [fms_pkg::ScoreW-1:0] skid_score_q, skid_score_d;
  logic                       pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_score_d  = out_score_q;
    skid_valid_d = skid_valid_q;
    skid_score_d = skid_score_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_score_d  = skid_score_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_score_d = score_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_score_d = score_i;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_score_q  <= out_score_d;
    skid_score_q <= skid_score_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;

  `FMS_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q, "skid holds a score with output empty")
  `FMS_ASSERT_IMPL(a_no_push_when_full, push_i, !skid_valid_q, "score pushed while skid is full")
  `FMS_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, out_valid_q && !skid_valid_q, "skid did not move to output")

endmodule

// File: tb/tb_filename_match_scorer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename match scorer core testbench
// streams name and path bytes into the scorer under random idle and stall
// bursts, predicts each score from the directed table or an in-bench model
// of the matching rules and compares every returned score with the oldest
// prediction

module tb_filename_match_scorer_core;

  localparam int PhaseCount = 10;
  localparam int PhaseItems = 80;
  localparam int HoldCycles = 100;
  localparam int DirCount = 28;
  localparam int QuerySwapRow = 3;

  localparam logic NameByte = 1'b0;
  localparam logic PathByte = 1'b1;
  localparam logic [fms_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int StyleLetters = 0;
  localparam int StyleOnes    = 1;
  localparam int StyleZeros   = 2;
  localparam int StyleRandom  = 3;

  localparam int LenPlan [PhaseCount] = '{4, 16, 0, 31, 3, 1, 8, -1, -1, -1};
  localparam int StylePlan [PhaseCount] = '{
    StyleLetters, StyleLetters, StyleLetters, StyleOnes, StyleZeros,
    StyleRandom, StyleLetters, StyleRandom, StyleLetters, StyleLetters
  };

  typedef enum int {
    KindExact, KindPrefix, KindInside, KindPath, KindSubseq,
    KindMixed, KindRandom, KindNoise, KindLong
  } cand_kind_e;

  typedef struct packed {
    logic                       act;
    logic [7:0]                 data;
    logic                       last;
    logic                       typed;
    logic [fms_pkg::ScoreW-1:0] score;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    '{NameByte, 8'h00, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'hff, 1'b1, 1'b1, fms_pkg::ScoreExact},
    '{PathByte, 8'h00, 1'b1, 1'b1, fms_pkg::ScorePath},
    '{NameByte, 8'h41, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h62, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'hff, 1'b1, 1'b1, fms_pkg::ScoreExact},
    '{NameByte, 8'h61, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h42, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h5a, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h00, 1'b1, 1'b1, fms_pkg::ScorePrefix},
    '{NameByte, 8'h5f, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h61, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h62, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h2f, 1'b1, 1'b1, fms_pkg::ScoreName},
    '{PathByte, 8'h41, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h62, 1'b1, 1'b1, fms_pkg::ScorePath},
    '{NameByte, 8'h61, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h40, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h5b, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h42, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h7b, 1'b1, 1'b1, fms_pkg::ScoreSubseq},
    '{NameByte, 8'h42, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h61, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h80, 1'b1, 1'b1, fms_pkg::ScoreNone},
    '{NameByte, 8'h61, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h61, 1'b0, 1'b0, fms_pkg::ScoreNone},
    '{NameByte, 8'h62, 1'b1, 1'b0, fms_pkg::ScoreNone},
    '{PathByte, 8'h62, 1'b1, 1'b0, fms_pkg::ScoreNone}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fms_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [fms_pkg::CfgW-1:0]    cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        action_i;
  logic [7:0]                  text_byte_i;
  logic                        ends_string_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [fms_pkg::ScoreW-1:0]  score_o;

  // query registers as the scorer should hold them
  logic [63:0] q_low;
  logic [63:0] q_high;
  logic [4:0]  q_len;

  // per-candidate match trackers
  logic [15:0] name_hits;
  logic [15:0] path_hits;
  bit          name_found;
  bit          path_found;
  bit          prefix_ok;
  int          name_count;
  int          subseq_at;

  logic [fms_pkg::ScoreW-1:0] score_q [$];
  logic [fms_pkg::ScoreW-1:0] want_score;
  int errors;
  int n_requests;
  int n_scores;
  int holds_done;
  int score_tally [6];
  bit calm;
  bit tx_bursty;
  bit rx_bursty;
  bit hold_req;

  filename_match_scorer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .text_byte_i  (text_byte_i),
    .ends_string_i(ends_string_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .score_o      (score_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic int used_len();
    int l;
    l = q_len;
    if (l < 1) l = 1;
    if (l > fms_pkg::QueryMax) l = fms_pkg::QueryMax;
    return l;
  endfunction

  function automatic logic [7:0] query_char(input int k);
    logic [63:0] w;
    w = (k < 8) ? q_low : q_high;
    return lower_ascii(w[8*(k%8) +: 8]);
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic [7:0] f;
    f = c | 8'h20;
    if (f >= 8'h61 && f <= 8'h7a && $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // mostly query bytes so that matches happen, the rest anything
  function automatic logic [7:0] text_pick();
    if ($urandom_range(0, 99) < 55) begin
      return vary_case(query_char($urandom_range(0, used_len() - 1)));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] make_query_word(input int style);
    logic [63:0] w;
    for (int b = 0; b < 8; b++) begin
      case (style)
        StyleLetters: w[8*b +: 8] = vary_case(8'h61 + 8'($urandom_range(0, 4)));
        StyleOnes:    w[8*b +: 8] = 8'hff;
        StyleZeros:   w[8*b +: 8] = 8'h00;
        default:      w[8*b +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return w;
  endfunction

  function automatic void clear_trackers();
    name_hits = '0;
    path_hits = '0;
    name_found = 1'b0;
    path_found = 1'b0;
    prefix_ok = 1'b1;
    name_count = 0;
    subseq_at = 0;
  endfunction

  // one accepted request; returns 1 when it completes a candidate
  function automatic bit absorb_byte(input logic act, input logic [7:0] data,
                                     input logic last,
                                     output logic [fms_pkg::ScoreW-1:0] sc);
    logic [7:0]  c;
    logic [15:0] mask;
    int          len;
    c = lower_ascii(data);
    len = used_len();
    mask = '0;
    sc = fms_pkg::ScoreNone;
    for (int k = 0; k < len; k++) begin
      if (query_char(k) == c) mask[k] = 1'b1;
    end
    if (act == NameByte) begin
      name_hits = ((name_hits << 1) | 16'd1) & mask;
      if (name_hits[len-1]) name_found = 1'b1;
      if (name_count < len && query_char(name_count) != c) prefix_ok = 1'b0;
      if (name_count < fms_pkg::NameMax) name_count++;
      if (subseq_at < len && query_char(subseq_at) == c) subseq_at++;
      return 1'b0;
    end
    path_hits = ((path_hits << 1) | 16'd1) & mask;
    if (path_hits[len-1]) path_found = 1'b1;
    if (!last) return 1'b0;
    if (prefix_ok && name_count == len) sc = fms_pkg::ScoreExact;
    else if (prefix_ok && name_count > len) sc = fms_pkg::ScorePrefix;
    else if (name_found) sc = fms_pkg::ScoreName;
    else if (path_found) sc = fms_pkg::ScorePath;
    else if (subseq_at >= len) sc = fms_pkg::ScoreSubseq;
    else sc = fms_pkg::ScoreNone;
    clear_trackers();
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [fms_pkg::CfgIdxW-1:0] idx,
                           input logic [fms_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      fms_pkg::CfgQueryLow:  q_low = data;
      fms_pkg::CfgQueryHigh: q_high = data;
      fms_pkg::CfgQueryLen:  q_len = data[4:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_req(input logic act, input logic [7:0] data, input logic last,
                          input bit typed, input logic [fms_pkg::ScoreW-1:0] typed_score);
    int                         gap;
    bit                         made;
    logic [fms_pkg::ScoreW-1:0] sc;
    gap = 0;
    if (!calm && tx_bursty && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    text_byte_i <= data;
    ends_string_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_requests++;
    made = absorb_byte(act, data, last, sc);
    if (made) begin
      if (typed) sc = typed_score;
      score_q = {score_q, sc};
      case (sc)
        fms_pkg::ScoreExact:  score_tally[0]++;
        fms_pkg::ScorePrefix: score_tally[1]++;
        fms_pkg::ScoreName:   score_tally[2]++;
        fms_pkg::ScorePath:   score_tally[3]++;
        fms_pkg::ScoreSubseq: score_tally[4]++;
        default:              score_tally[5]++;
      endcase
    end
  endtask

  task automatic wait_scores();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (score_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (score_q.size() != 0) begin
      $display("%0t: %0d expected scores never arrived", $time, score_q.size());
      errors++;
      score_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_candidate(input cand_kind_e kind);
    logic [7:0] nm [$];
    logic [7:0] pa [$];
    int         len;
    int         i;
    int         j;
    int         mark;
    bit         mix;
    len = used_len();
    mix = (kind == KindMixed);
    mark = -1;
    tx_bursty = ($urandom_range(0, 3) != 0);
    if (kind == KindNoise) begin
      repeat ($urandom_range(1, 6)) begin
        send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b0, fms_pkg::ScoreNone);
      end
    end
    case (kind)
      KindExact, KindPrefix, KindLong: begin
        for (int k = 0; k < len; k++) nm = {nm, vary_case(query_char(k))};
        if (kind == KindExact && $urandom_range(0, 3) == 0) begin
          nm[$urandom_range(0, len - 1)] = text_pick();
        end
        if (kind == KindPrefix) repeat ($urandom_range(1, 5)) nm = {nm, text_pick()};
        if (kind == KindLong) repeat ($urandom_range(240, 300)) nm = {nm, text_pick()};
      end
      KindInside: begin
        repeat ($urandom_range(1, 4)) nm = {nm, text_pick()};
        for (int k = 0; k < len; k++) nm = {nm, vary_case(query_char(k))};
        repeat ($urandom_range(0, 3)) nm = {nm, text_pick()};
      end
      KindPath: begin
        repeat ($urandom_range(1, 6)) nm = {nm, text_pick()};
        repeat ($urandom_range(0, 3)) pa = {pa, text_pick()};
        for (int k = 0; k < len; k++) pa = {pa, vary_case(query_char(k))};
        repeat ($urandom_range(0, 3)) pa = {pa, text_pick()};
      end
      KindSubseq: begin
        for (int k = 0; k < len; k++) begin
          repeat ($urandom_range(0, 2)) nm = {nm, text_pick()};
          nm = {nm, vary_case(query_char(k))};
        end
      end
      KindMixed: begin
        for (int k = 0; k < len; k++) nm = {nm, vary_case(query_char(k))};
        repeat ($urandom_range(0, 3)) pa = {pa, text_pick()};
        for (int k = 0; k < len; k++) pa = {pa, vary_case(query_char(k))};
      end
      default: begin
        repeat ($urandom_range(0, 10)) nm = {nm, text_pick()};
      end
    endcase
    if (pa.size() == 0) repeat ($urandom_range(1, 8)) pa = {pa, text_pick()};
    // stray end marks inside the name
    if (nm.size() > 1 && $urandom_range(0, 7) == 0) mark = $urandom_range(0, nm.size() - 2);
    i = 0;
    j = 0;
    while (i < nm.size() || j < pa.size()) begin
      if (i < nm.size() && (!mix || j == pa.size() - 1 || $urandom_range(0, 1) == 1)) begin
        send_req(NameByte, nm[i], (i == nm.size() - 1) || (i == mark), 1'b0,
                 fms_pkg::ScoreNone);
        i++;
      end else begin
        send_req(PathByte, pa[j], j == pa.size() - 1, 1'b0, fms_pkg::ScoreNone);
        j++;
      end
    end
  endtask

  // score checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (score_q.size() == 0) begin
        $display("%0t: score %0d with nothing expected", $time, score_o);
        errors++;
      end else begin
        want_score = score_q.pop_front();
        n_scores++;
        if (score_o !== want_score) begin
          $display("%0t: score mismatch, expected %0d, got %0d", $time, want_score, score_o);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int ticks;
    out_stall_i = 1'b0;
    rx_bursty = 1'b1;
    ticks = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && rx_bursty && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      ticks++;
      if (ticks % 160 == 0) rx_bursty = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    #4800000;
    $display("tb_filename_match_scorer_core: errors");
    $finish;
  end

  initial begin
    int                       ph;
    int                       len;
    int                       goal;
    int                       r;
    logic [fms_pkg::CfgW-1:0] word;
    cand_kind_e               kind;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = fms_pkg::CfgQueryLow;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = NameByte;
    text_byte_i = 8'h00;
    ends_string_i = 1'b0;
    errors = 0;
    n_requests = 0;
    n_scores = 0;
    holds_done = 0;
    foreach (score_tally[k]) score_tally[k] = 0;
    calm = 1'b0;
    tx_bursty = 1'b1;
    hold_req = 1'b0;
    q_low = '0;
    q_high = '0;
    q_len = 5'd1;
    clear_trackers();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // directed requests, reset query first, then a two byte query
    for (int i = 0; i < DirCount; i++) begin
      if (i == QuerySwapRow) begin
        wait_scores();
        write_reg(CfgSpare, {$urandom, $urandom});
        write_reg(fms_pkg::CfgQueryLow, 64'ha5a5_a5a5_a5a5_4261);
        write_reg(fms_pkg::CfgQueryHigh, 64'hffff_ffff_ffff_ffff);
        write_reg(fms_pkg::CfgQueryLen, 64'd2);
      end
      send_req(DirRows[i].act, DirRows[i].data, DirRows[i].last, DirRows[i].typed,
               DirRows[i].score);
    end

    // random candidates, one query setting per phase
    for (ph = 0; ph < PhaseCount; ph++) begin
      wait_scores();
      len = (LenPlan[ph] < 0) ? $urandom_range(1, 16) : LenPlan[ph];
      word = {$urandom, $urandom};
      if (ph % 2 == 1) word[63:5] = '0;
      word[4:0] = 5'(len);
      write_reg(fms_pkg::CfgQueryLow, make_query_word(StylePlan[ph]));
      write_reg(fms_pkg::CfgQueryHigh, make_query_word(StylePlan[ph]));
      write_reg(fms_pkg::CfgQueryLen, word);
      calm = (ph >= PhaseCount - 2);
      if (ph == 1) hold_req = 1'b1;
      goal = n_requests + PhaseItems;
      if (ph == 3 || ph == 6) send_candidate(KindLong);
      while (n_requests < goal) begin
        r = $urandom_range(0, 99);
        if (r < 14) kind = KindExact;
        else if (r < 26) kind = KindPrefix;
        else if (r < 40) kind = KindInside;
        else if (r < 54) kind = KindPath;
        else if (r < 68) kind = KindSubseq;
        else if (r < 80) kind = KindMixed;
        else if (r < 90) kind = KindRandom;
        else kind = KindNoise;
        send_candidate(kind);
      end
    end
    wait_scores();

    $display("%0d requests, %0d scores checked (1000:%0d 500:%0d 100:%0d 50:%0d 25:%0d 0:%0d)",
             n_requests, n_scores, score_tally[0], score_tally[1], score_tally[2],
             score_tally[3], score_tally[4], score_tally[5]);
    $display("query lengths 1 to 16 with clamped 0 and 31, long names, %0d output hold-off",
             holds_done);
    if (errors == 0) begin
      $display("tb_filename_match_scorer_core: clean");
    end else begin
      $display("tb_filename_match_scorer_core: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/fms_pkg.sv
rtl/fms_cell.sv
rtl/fms_out_buf.sv
rtl/filename_match_scorer_core.sv
tb/tb_filename_match_scorer_core.sv
